### sv/chts_pkg.sv
// shared types and constants for the character hit test search unit
// no dependencies: every other file takes its names from here
package chts_pkg;

   // default table depth in glyphs
   localparam int MAX_GLYPHS_DEFAULT = 256;

   // widths fixed by the item fields
   localparam int COORD_W = 16;
   localparam int WIDTH_W = 12;
   localparam int INDEX_W = 8;

   // bounds get two bits over a coordinate, room to add or take off half of a width
   localparam int BOUND_W = COORD_W + 2;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE        = 2'd0,
      ST_CHECK_FIRST = 2'd1,
      ST_SEARCH      = 2'd2
   } state_type;

   typedef struct packed {
      logic [1:0]                 operation;
      logic signed [COORD_W-1:0]  glyph_x;
      logic [WIDTH_W-1:0]         glyph_width;
      logic signed [COORD_W-1:0]  query_x;
      logic                       line_absent;
   } req_type;

   typedef struct packed {
      logic               after_last;
      logic [INDEX_W-1:0] glyph_index;
   } rsp_type;

   // one table row: the glyph and the width of the glyph before it
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic [WIDTH_W-1:0]        width;
      logic [WIDTH_W-1:0]        prev_width;
   } glyph_entry_type;

endpackage

### sv/chts_glyph_mem.sv
// glyph table: one write port, one read port with registered read data
// depends on chts_pkg for the row type
module chts_glyph_mem #(
   parameter int DEPTH = chts_pkg::MAX_GLYPHS_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  chts_pkg::glyph_entry_type  wr_data,
   input  logic [AW-1:0]              rd_addr,
   output chts_pkg::glyph_entry_type  rd_data
);

   chts_pkg::glyph_entry_type mem [DEPTH];
   chts_pkg::glyph_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/chts_search_ctrl.sv
// command decode, glyph count and the binary search sequencer
// depends on chts_pkg; drives the ports of chts_glyph_mem
module chts_search_ctrl #(
   parameter int MAX_GLYPHS = chts_pkg::MAX_GLYPHS_DEFAULT,
   parameter int AW         = $clog2(MAX_GLYPHS),
   parameter int CW         = $clog2(MAX_GLYPHS + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  chts_pkg::req_type          req_item,
   output logic                       rsp_valid,
   output chts_pkg::rsp_type          rsp_item,
   output logic                       mem_wr_en,
   output logic [AW-1:0]              mem_wr_addr,
   output chts_pkg::glyph_entry_type  mem_wr_data,
   output logic [AW-1:0]              mem_rd_addr,
   input  chts_pkg::glyph_entry_type  mem_rd_data
);

   localparam int SW = CW + 1;

   chts_pkg::state_type state_ff, state_in;
   logic [CW-1:0]                    count_ff, count_in;
   logic [chts_pkg::WIDTH_W-1:0]     last_width_ff, last_width_in;
   logic [CW-1:0]                    lo_ff, lo_in;
   logic [CW-1:0]                    hx_ff, hx_in;
   logic [AW-1:0]                    mid_ff, mid_in;
   logic signed [chts_pkg::COORD_W-1:0] qx_ff, qx_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   chts_pkg::rsp_type                rsp_item_ff, rsp_item_in;

   logic                             accept;
   logic                             query_trivial;
   logic signed [chts_pkg::BOUND_W-1:0] qx_ext;
   logic signed [chts_pkg::BOUND_W-1:0] x_ext;
   logic signed [chts_pkg::BOUND_W-1:0] right_bound;
   logic signed [chts_pkg::BOUND_W-1:0] left_bound;
   logic                             go_left;
   logic                             go_right;
   logic                             hit;
   logic [CW-1:0]                    step_lo;
   logic [CW-1:0]                    step_hx;
   logic [SW-1:0]                    mid_sum;
   logic [AW-1:0]                    step_mid;
   logic                             step_more;

   assign busy   = (state_ff != chts_pkg::ST_IDLE);
   assign accept = start && !busy;
   assign query_trivial = req_item.line_absent || (count_ff == '0);

   // bounds of the glyph whose row was read last cycle
   assign qx_ext = chts_pkg::BOUND_W'(qx_ff);
   assign x_ext  = chts_pkg::BOUND_W'(mem_rd_data.x);
   assign right_bound = x_ext
                      + $signed(chts_pkg::BOUND_W'(mem_rd_data.width >> 1))
                      - $signed(chts_pkg::BOUND_W'(!mem_rd_data.width[0]));
   assign left_bound  = x_ext
                      - $signed(chts_pkg::BOUND_W'(mem_rd_data.prev_width >> 1));

   // left of the span wins when the span is empty
   assign go_left  = (state_ff == chts_pkg::ST_SEARCH) && (qx_ext < left_bound);
   assign go_right = !go_left && (qx_ext > right_bound);
   assign hit      = !go_left && !go_right;

   // search window as [lo, hx) after this step
   always_comb begin
      if (state_ff == chts_pkg::ST_CHECK_FIRST) begin
         step_lo = CW'(1);
         step_hx = count_ff;
      end else begin
         step_lo = go_right ? (CW'(mid_ff) + CW'(1)) : lo_ff;
         step_hx = go_left ? CW'(mid_ff) : hx_ff;
      end
   end

   assign step_more = (step_lo < step_hx);
   assign mid_sum   = SW'(step_lo) + SW'(step_hx) - SW'(1);
   assign step_mid  = mid_sum[AW:1];

   // row 0 on a query accept, otherwise the next probe
   assign mem_rd_addr = (state_ff == chts_pkg::ST_IDLE) ? '0 : step_mid;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         chts_pkg::ST_IDLE: begin
            if (accept && (req_item.operation == chts_pkg::OP_QUERY) && !query_trivial) begin
               state_in = chts_pkg::ST_CHECK_FIRST;
            end
         end
         chts_pkg::ST_CHECK_FIRST: begin
            if (go_right && step_more) begin
               state_in = chts_pkg::ST_SEARCH;
            end else begin
               state_in = chts_pkg::ST_IDLE;
            end
         end
         chts_pkg::ST_SEARCH: begin
            if (hit || !step_more) begin
               state_in = chts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = chts_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in      = count_ff;
      last_width_in = last_width_ff;
      lo_in         = lo_ff;
      hx_in         = hx_ff;
      mid_in        = mid_ff;
      qx_in         = qx_ff;
      rsp_valid_in  = 1'b0;
      rsp_item_in   = rsp_item_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = count_ff[AW-1:0];
      mem_wr_data.x          = req_item.glyph_x;
      mem_wr_data.width      = req_item.glyph_width;
      mem_wr_data.prev_width = last_width_ff;
      case (state_ff)
         chts_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_item.operation)
                  chts_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  chts_pkg::OP_APPEND: begin
                     if (count_ff < CW'(MAX_GLYPHS)) begin
                        mem_wr_en     = 1'b1;
                        count_in      = count_ff + CW'(1);
                        last_width_in = req_item.glyph_width;
                     end
                  end
                  chts_pkg::OP_QUERY: begin
                     qx_in  = req_item.query_x;
                     mid_in = '0;
                     if (query_trivial) begin
                        rsp_valid_in = 1'b1;
                        rsp_item_in.after_last  = 1'b1;
                        rsp_item_in.glyph_index = '0;
                     end
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
            end
         end
         chts_pkg::ST_CHECK_FIRST, chts_pkg::ST_SEARCH: begin
            if (hit) begin
               rsp_valid_in = 1'b1;
               rsp_item_in.after_last  = 1'b0;
               rsp_item_in.glyph_index = chts_pkg::INDEX_W'(mid_ff);
            end else if (!step_more) begin
               rsp_valid_in = 1'b1;
               rsp_item_in.after_last  = 1'b1;
               rsp_item_in.glyph_index = '0;
            end else begin
               lo_in  = step_lo;
               hx_in  = step_hx;
               mid_in = step_mid;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chts_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_width_ff <= last_width_in;
      lo_ff         <= lo_in;
      hx_ff         <= hx_in;
      mid_ff        <= mid_in;
      qx_ff         <= qx_in;
      rsp_item_ff   <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_GLYPHS))
      else $error("glyph count beyond table depth");

   a_miss_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.after_last |-> rsp_item_ff.glyph_index == '0)
      else $error("miss reported with non-zero index");

   a_append_counts: assert property (@(posedge clock) disable iff (reset)
      accept && (req_item.operation == chts_pkg::OP_APPEND) && (count_ff < CW'(MAX_GLYPHS))
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("append did not advance glyph count");

   a_search_needs_two: assert property (@(posedge clock) disable iff (reset)
      state_ff == chts_pkg::ST_SEARCH |-> count_ff > CW'(1))
      else $error("search running over fewer than two glyphs");

   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(busy) ||
         $past(accept && (req_item.operation == chts_pkg::OP_QUERY)))
      else $error("result strobe without a query");

endmodule

### sv/char_hit_test_search_unit.sv
// top level of the character hit test search unit
// depends on chts_pkg, chts_glyph_mem and chts_search_ctrl
//
// holds one laid-out text line as a table of glyphs (left x and width) and
// finds the glyph under an x coordinate. a transfer is taken when start is
// high and busy is low. clear and append give no result; an append to a
// full table is dropped. a query gives exactly one result, shown on
// rsp_item for one cycle with rsp_valid high; the receiver cannot hold it
// off, so it must take it in that cycle. a query on an absent or empty
// line answers after_last in the cycle after the transfer. any other
// query first checks glyph 0 and then runs a binary search over glyphs 1
// to n-1 with busy high, one row read per probe from the single read port
// of the glyph table. start may be taken again in the cycle the result is
// shown. the table rows are not cleared at reset: only rows below the
// glyph count are ever used
module char_hit_test_search_unit #(
   parameter int MAX_GLYPHS = chts_pkg::MAX_GLYPHS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  chts_pkg::req_type  req_item,
   output logic               rsp_valid,
   output chts_pkg::rsp_type  rsp_item
);

   // table address and glyph count widths
   localparam int AW = $clog2(MAX_GLYPHS);
   localparam int CW = $clog2(MAX_GLYPHS + 1);

   // table port between sequencer and memory
   logic                       mem_wr_en;
   logic [AW-1:0]              mem_wr_addr;
   chts_pkg::glyph_entry_type  mem_wr_data;
   logic [AW-1:0]              mem_rd_addr;
   chts_pkg::glyph_entry_type  mem_rd_data;

   // command decode, glyph count and the search loop
   chts_search_ctrl #(
      .MAX_GLYPHS (MAX_GLYPHS),
      .AW         (AW),
      .CW         (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // each row keeps the previous glyph's width too, so one read per probe
   // gives both bounds of the glyph
   chts_glyph_mem #(
      .DEPTH (MAX_GLYPHS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule
